/* hdl/exposure_countdown_controller_defines.svh */
// Assertion helpers for the top-level RTL file, exposure_countdown_controller.sv.
`ifndef EXPOSURE_COUNTDOWN_CONTROLLER_DEFINES_SVH
`define EXPOSURE_COUNTDOWN_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ECC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ECC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/ecc_pkg.sv */
`default_nettype none
package ecc_pkg;

   localparam int DEFAULT_DURATION_DEF = 60;
   localparam int TIME_BITS_DEF        = 16;
   localparam logic [7:0] FAN_OVERRUN_RESET = 8'd10;

   localparam logic [2:0] EV_TICK   = 3'd0;
   localparam logic [2:0] EV_START  = 3'd1;
   localparam logic [2:0] EV_PAUSE  = 3'd2;
   localparam logic [2:0] EV_CANCEL = 3'd3;
   localparam logic [2:0] EV_RESET  = 3'd4;
   localparam logic [2:0] EV_ADJUST = 3'd5;

   localparam logic [2:0] MODE_IDLE      = 3'd0;
   localparam logic [2:0] MODE_RUNNING   = 3'd1;
   localparam logic [2:0] MODE_PAUSED    = 3'd2;
   localparam logic [2:0] MODE_FINISHED  = 3'd3;
   localparam logic [2:0] MODE_CANCELLED = 3'd4;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [15:0] adjust_delta;
   } ecc_req_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] remaining_seconds;
      logic        lamp_on;
      logic        fan_on;
   } ecc_rsp_type;

   // Control state that travels between the state registers and the event logic.
   typedef struct packed {
      logic [2:0] mode;
      logic       lamp;
      logic       fan;
      logic [7:0] runon;
   } ecc_ctl_type;

endpackage
`default_nettype wire

/* hdl/ecc_event_logic.sv */
`default_nettype none
module ecc_event_logic #(
   parameter int TIME_BITS = 16
) (
   input  ecc_pkg::ecc_req_type req,
   input  ecc_pkg::ecc_ctl_type ctl_cur,
   input  logic [TIME_BITS-1:0] remaining_cur,
   input  logic [TIME_BITS-1:0] saved_cur,
   input  logic [7:0]           fan_overrun,
   output ecc_pkg::ecc_ctl_type ctl_nxt,
   output logic [TIME_BITS-1:0] remaining_nxt,
   output logic [TIME_BITS-1:0] saved_nxt
);
   import ecc_pkg::*;

   localparam int WIDE = (TIME_BITS > 16) ? TIME_BITS : 16;
   localparam int SUM_BITS = WIDE + 2;

   logic signed [SUM_BITS-1:0] sum;
   logic [TIME_BITS-1:0]       adjusted;

   assign sum = $signed({{(SUM_BITS - TIME_BITS){1'b0}}, remaining_cur})
              + SUM_BITS'(req.adjust_delta);

   always_comb begin
      if (sum[SUM_BITS-1]) begin
         adjusted = '0;
      end else if (sum[SUM_BITS-2:TIME_BITS] != '0) begin
         adjusted = '1;
      end else begin
         adjusted = sum[TIME_BITS-1:0];
      end
   end

   always_comb begin
      logic halt;
      logic run;
      logic [2:0] halt_mode;
      halt          = 1'b0;
      run           = 1'b0;
      halt_mode     = MODE_IDLE;
      ctl_nxt       = ctl_cur;
      remaining_nxt = remaining_cur;
      saved_nxt     = saved_cur;
      case (req.req_type)
         EV_TICK: begin
            if (ctl_cur.mode == MODE_RUNNING) begin
               ctl_nxt.fan   = 1'b1;
               ctl_nxt.runon = '0;
               if (remaining_cur != '0) begin
                  remaining_nxt = remaining_cur - TIME_BITS'(1);
               end else begin
                  halt      = 1'b1;
                  halt_mode = MODE_FINISHED;
               end
            end else if (ctl_cur.runon != '0) begin
               ctl_nxt.runon = ctl_cur.runon - 8'd1;
               if (ctl_cur.runon == 8'd1) begin
                  ctl_nxt.fan = 1'b0;
               end
            end
         end
         EV_START: begin
            run = (ctl_cur.mode == MODE_IDLE) || (ctl_cur.mode == MODE_PAUSED);
         end
         EV_PAUSE: begin
            if (ctl_cur.mode == MODE_RUNNING) begin
               halt      = 1'b1;
               halt_mode = MODE_PAUSED;
            end else if (ctl_cur.mode == MODE_PAUSED) begin
               run = 1'b1;
            end
         end
         EV_CANCEL: begin
            halt      = 1'b1;
            halt_mode = MODE_CANCELLED;
         end
         EV_RESET: begin
            if (ctl_cur.mode != MODE_RUNNING) begin
               remaining_nxt = saved_cur;
               halt          = 1'b1;
               halt_mode     = MODE_IDLE;
            end
         end
         EV_ADJUST: begin
            remaining_nxt = adjusted;
         end
         default: begin
         end
      endcase
      if (run) begin
         ctl_nxt.mode  = MODE_RUNNING;
         ctl_nxt.lamp  = 1'b1;
         ctl_nxt.fan   = 1'b1;
         ctl_nxt.runon = '0;
         saved_nxt     = remaining_cur;
      end
      if (halt) begin
         ctl_nxt.mode  = halt_mode;
         ctl_nxt.lamp  = 1'b0;
         ctl_nxt.runon = fan_overrun;
         if (fan_overrun == '0) begin
            ctl_nxt.fan = 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

/* hdl/ecc_rsp_stage.sv */
`default_nettype none
module ecc_rsp_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  ecc_pkg::ecc_rsp_type load_data,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ecc_pkg::ecc_rsp_type rsp_data
);
   import ecc_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   ecc_rsp_type data_ff;

   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

/* hdl/exposure_countdown_controller.sv */
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_ready  | req_data (ecc_req_type)
// rsp     | out       | rsp_valid / rsp_ready  | rsp_data (ecc_rsp_type)
// csr     | in        | csr_valid / csr_ready  | csr_data, fan run-on ticks
//
// One event per cycle while req_ready is high; its result is registered and shows in the cycle after the transfer.
// The event logic and the state update are combinational and sit between the state flops and the result flops.
// req_ready drops only while a result is held and rsp_ready is low; csr_ready is always high.
// Synchronous reset: idle, default duration loaded, lamp and fan off, run-on ticks ten.
`default_nettype none
`include "exposure_countdown_controller_defines.svh"
module exposure_countdown_controller #(
   parameter int DEFAULT_DURATION = ecc_pkg::DEFAULT_DURATION_DEF,
   parameter int TIME_BITS        = ecc_pkg::TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ecc_pkg::ecc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ecc_pkg::ecc_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_data
);
   import ecc_pkg::*;

   localparam int WIDE = (TIME_BITS > 16) ? TIME_BITS : 16;
   localparam logic [TIME_BITS-1:0] DURATION_RESET = TIME_BITS'(DEFAULT_DURATION);

   ecc_ctl_type          ctl_ff;
   ecc_ctl_type          ctl_in;
   logic [TIME_BITS-1:0] remaining_ff;
   logic [TIME_BITS-1:0] remaining_in;
   logic [TIME_BITS-1:0] saved_ff;
   logic [TIME_BITS-1:0] saved_in;
   logic [7:0]           overrun_ff;
   logic                 accept;
   logic [WIDE-1:0]      remaining_wide;
   ecc_rsp_type          rsp_next;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   ecc_event_logic #(
      .TIME_BITS(TIME_BITS)
   ) u_event (
      .req          (req_data),
      .ctl_cur      (ctl_ff),
      .remaining_cur(remaining_ff),
      .saved_cur    (saved_ff),
      .fan_overrun  (overrun_ff),
      .ctl_nxt      (ctl_in),
      .remaining_nxt(remaining_in),
      .saved_nxt    (saved_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.mode  <= MODE_IDLE;
         ctl_ff.lamp  <= 1'b0;
         ctl_ff.fan   <= 1'b0;
         ctl_ff.runon <= '0;
         remaining_ff <= DURATION_RESET;
         saved_ff     <= DURATION_RESET;
      end else if (accept) begin
         ctl_ff       <= ctl_in;
         remaining_ff <= remaining_in;
         saved_ff     <= saved_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overrun_ff <= FAN_OVERRUN_RESET;
      end else if (csr_valid && csr_ready) begin
         overrun_ff <= csr_data;
      end
   end

   assign remaining_wide              = WIDE'(remaining_in);
   assign rsp_next.mode               = ctl_in.mode;
   assign rsp_next.remaining_seconds  = remaining_wide[15:0];
   assign rsp_next.lamp_on            = ctl_in.lamp;
   assign rsp_next.fan_on             = ctl_in.fan;

   ecc_rsp_stage u_rsp (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .load_data(rsp_next),
      .can_load (req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   `ECC_ASSERT_SAME(a_lamp_only_running, clock, reset, ctl_ff.lamp, ctl_ff.mode == MODE_RUNNING, "lamp on outside running")
   `ECC_ASSERT_SAME(a_fan_while_running, clock, reset, ctl_ff.mode == MODE_RUNNING, ctl_ff.fan, "fan off while running")
   `ECC_ASSERT_SAME(a_no_runon_running, clock, reset, ctl_ff.mode == MODE_RUNNING, ctl_ff.runon == '0, "run-on count while running")
   `ECC_ASSERT_NEXT(a_transfer_gives_rsp, clock, reset, accept, rsp_valid, "transfer without result")

endmodule
`default_nettype wire
